// File: sv/sasw_pkg.sv
// shared constants, types and encodings for the selective-ack send window
// no dependencies
package sasw_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 << IDX_W;
  localparam int SEQ_W  = 32;
  localparam int OUT_W  = 72;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_PENDING,
    ST_ACKED
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK_MARK,
    S_WALK_RD,
    S_WALK,
    S_RESULT
  } state_t;

  typedef enum logic {
    OP_PUSH,
    OP_ACK
  } op_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    status_t           wdata;
    logic [ADDR_W-1:0] raddr;
    logic              clr;
    logic              clr_bank;
  } mem_req_t;

  typedef struct packed {
    logic             accepted;
    logic [SEQ_W-1:0] assigned_seq;
    logic             bank_swapped;
    logic [SEQ_W-1:0] lowest_unacked_seq;
  } res_t;

endpackage

// File: sv/selective_ack_send_window.sv
// selective-ack send window: sender-side slot bookkeeping over two banks
// path to m_tvalid: push or missed ack via S_RESULT; ack of an already acked slot via
// S_ACK_MARK, S_RESULT; new ack via S_ACK_MARK, S_WALK_RD, S_WALK (the unacked pointer
// walks over the acked slots), S_RESULT; one request in flight, one slot status memory
// read per cycle; the next request is taken in the cycle after the result loads
// reset: synchronous; all slots empty, bank bases 0 and SLOTS, no clearing pass
module selective_ack_send_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,  // ack_seq
  input  logic [0:0]                 s_tuser,  // op
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // accepted, assigned_seq, bank_swapped, lowest_unacked_seq, zero fill
  output logic [sasw_pkg::OUT_W-1:0] m_tdata
);

  sasw_pkg::mem_req_t mem_req;
  sasw_pkg::status_t  status;
  sasw_pkg::res_t     res;
  logic               res_valid;
  logic               res_ready;

  sasw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (sasw_pkg::op_t'(s_tuser[0])),
    .in_seq    (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .status    (status)
  );

  sasw_slot_ram u_ram (
    .clk    (clk),
    .rst    (rst),
    .req    (mem_req),
    .status (status)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {6'b0, res.lowest_unacked_seq, res.bank_swapped,
                  res.assigned_seq, res.accepted};
    end
  end

  a_busy_excl : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !s_tready)
    else $error("input ready while a result is pending");

  a_swap_needs_ack : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> !m_tdata[33])
    else $error("bank swap without a new acknowledgment");

  a_seq_needs_accept : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
    else $error("sequence number given on a refused request");

  a_result_loads : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_tvalid)
    else $error("result lost on output load");

endmodule

// File: sv/sasw_slot_ram.sv
// slot status memory, both banks, one write and one registered read per cycle
// per-slot valid bits make unwritten or cleared slots read as empty; uses sasw_pkg
module sasw_slot_ram (
  input  logic               clk,
  input  logic               rst,
  input  sasw_pkg::mem_req_t req,
  output sasw_pkg::status_t  status
);

  sasw_pkg::status_t            mem [sasw_pkg::DEPTH];
  sasw_pkg::status_t            rdata;
  logic                         rvalid;
  logic [sasw_pkg::DEPTH-1:0]   valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata  <= mem[req.raddr];
    rvalid <= valid[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < sasw_pkg::DEPTH; i++) begin
        if (req.clr && (i >= (int'(req.clr_bank) << sasw_pkg::IDX_W))
            && (i < ((int'(req.clr_bank) + 1) << sasw_pkg::IDX_W))) begin
          valid[i] <= 1'b0;
        end
      end
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
    end
  end

  assign status = rvalid ? rdata : sasw_pkg::ST_EMPTY;

endmodule

// File: sv/sasw_ctrl.sv
// request sequencer: bank registers, push and ack handling, unacked pointer walk
// drives the slot status memory; uses sasw_pkg
module sasw_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sasw_pkg::op_t            in_op,
  input  logic [sasw_pkg::SEQ_W-1:0] in_seq,
  output logic                     res_valid,
  input  logic                     res_ready,
  output sasw_pkg::res_t           res,
  output sasw_pkg::mem_req_t       mem_req,
  input  sasw_pkg::status_t        status
);

  sasw_pkg::state_t             state, state_next;
  logic                         cur;
  logic [sasw_pkg::SEQ_W-1:0]   base  [2];
  logic [sasw_pkg::CNT_W-1:0]   fill  [2];
  logic [sasw_pkg::CNT_W-1:0]   first [2];
  logic                         b;
  logic [sasw_pkg::IDX_W-1:0]   off;
  logic [sasw_pkg::CNT_W-1:0]   p;
  logic [sasw_pkg::CNT_W-1:0]   p_plus;
  logic                         acc;
  logic [sasw_pkg::SEQ_W-1:0]   given;
  logic                         swapped;

  logic                         oth;
  logic [sasw_pkg::SEQ_W-1:0]   off_o, off_c, off_sel;
  logic                         hit_o, hit_c, hit_any, hit_bank;
  logic                         cur_full, oth_full, push_ok, push_bank;
  logic                         walk_done, swap_now, mark_new;

  always_comb begin
    oth       = ~cur;
    off_o     = in_seq - base[oth];
    off_c     = in_seq - base[cur];
    hit_o     = off_o < sasw_pkg::SEQ_W'(sasw_pkg::SLOTS);
    hit_c     = off_c < sasw_pkg::SEQ_W'(sasw_pkg::SLOTS);
    hit_any   = hit_o || hit_c;
    hit_bank  = hit_o ? oth : cur;
    off_sel   = hit_o ? off_o : off_c;
    cur_full  = fill[cur] >= sasw_pkg::CNT_W'(sasw_pkg::SLOTS);
    oth_full  = fill[oth] >= sasw_pkg::CNT_W'(sasw_pkg::SLOTS);
    push_ok   = !(cur_full && oth_full);
    push_bank = cur_full ? oth : cur;
    p_plus    = p + sasw_pkg::CNT_W'(1);
    walk_done = (p == sasw_pkg::CNT_W'(sasw_pkg::SLOTS)) || (status != sasw_pkg::ST_ACKED);
    swap_now  = (b == cur) && (p == sasw_pkg::CNT_W'(sasw_pkg::SLOTS));
    mark_new  = status != sasw_pkg::ST_ACKED;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sasw_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == sasw_pkg::OP_ACK && hit_any) begin
            state_next = sasw_pkg::S_ACK_MARK;
          end else begin
            state_next = sasw_pkg::S_RESULT;
          end
        end
      end
      sasw_pkg::S_ACK_MARK: begin
        state_next = mark_new ? sasw_pkg::S_WALK_RD : sasw_pkg::S_RESULT;
      end
      sasw_pkg::S_WALK_RD: begin
        state_next = sasw_pkg::S_WALK;
      end
      sasw_pkg::S_WALK: begin
        if (walk_done) begin
          state_next = sasw_pkg::S_RESULT;
        end
      end
      sasw_pkg::S_RESULT: begin
        if (res_ready) begin
          state_next = sasw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sasw_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and memory requests
  always_comb begin
    in_ready  = state == sasw_pkg::S_IDLE;
    res_valid = state == sasw_pkg::S_RESULT;
    res.accepted           = acc;
    res.assigned_seq       = given;
    res.bank_swapped       = swapped;
    res.lowest_unacked_seq = base[cur] + sasw_pkg::SEQ_W'(first[cur]);
    mem_req.we       = 1'b0;
    mem_req.waddr    = {push_bank, fill[push_bank][sasw_pkg::IDX_W-1:0]};
    mem_req.wdata    = sasw_pkg::ST_PENDING;
    mem_req.raddr    = {hit_bank, off_sel[sasw_pkg::IDX_W-1:0]};
    mem_req.clr      = 1'b0;
    mem_req.clr_bank = cur;
    case (state)
      sasw_pkg::S_IDLE: begin
        mem_req.we = in_valid && (in_op == sasw_pkg::OP_PUSH) && push_ok;
      end
      sasw_pkg::S_ACK_MARK: begin
        mem_req.we    = mark_new;
        mem_req.waddr = {b, off};
        mem_req.wdata = sasw_pkg::ST_ACKED;
      end
      sasw_pkg::S_WALK_RD: begin
        mem_req.raddr = {b, first[b][sasw_pkg::IDX_W-1:0]};
      end
      sasw_pkg::S_WALK: begin
        mem_req.raddr = {b, p_plus[sasw_pkg::IDX_W-1:0]};
        mem_req.clr   = walk_done && swap_now;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sasw_pkg::S_IDLE;
      cur      <= 1'b0;
      base[0]  <= '0;
      base[1]  <= sasw_pkg::SEQ_W'(sasw_pkg::SLOTS);
      fill[0]  <= '0;
      fill[1]  <= '0;
      first[0] <= '0;
      first[1] <= '0;
    end else begin
      state <= state_next;
      case (state)
        sasw_pkg::S_IDLE: begin
          if (in_valid) begin
            swapped <= 1'b0;
            if (in_op == sasw_pkg::OP_PUSH) begin
              acc   <= push_ok;
              given <= push_ok ? base[push_bank] + sasw_pkg::SEQ_W'(fill[push_bank]) : '0;
              if (push_ok) begin
                fill[push_bank] <= fill[push_bank] + sasw_pkg::CNT_W'(1);
              end
            end else begin
              acc   <= 1'b0;
              given <= '0;
              b     <= hit_bank;
              off   <= off_sel[sasw_pkg::IDX_W-1:0];
            end
          end
        end
        sasw_pkg::S_ACK_MARK: begin
          acc <= mark_new;
        end
        sasw_pkg::S_WALK_RD: begin
          p <= first[b];
        end
        sasw_pkg::S_WALK: begin
          if (walk_done) begin
            if (swap_now) begin
              cur        <= oth;
              base[cur]  <= base[oth] + sasw_pkg::SEQ_W'(sasw_pkg::SLOTS);
              fill[cur]  <= '0;
              first[cur] <= '0;
              swapped    <= 1'b1;
            end else begin
              first[b] <= p;
            end
          end else begin
            p <= p_plus;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
